[hw/rtl/fbbe_pkg.sv]
// ----------------------------------------------------------------------------
// fbbe_pkg
// Shared widths, codes, defaults and types of the byte budget eviction unit.
// ----------------------------------------------------------------------------
package fbbe_pkg;

	// field widths
	localparam int ROW_W      = 10;
	localparam int DIM_W      = 13;
	localparam int BPP_W      = 7;
	localparam int COST_W     = 28;
	localparam int TOTAL_W    = 38;
	localparam int ROWCNT_W   = 11;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = TOTAL_W;

	// log2 of the bits per byte, the shift for the cost calculation
	localparam int BYTE_SHIFT = 3;

	// default sizes
	localparam int DEF_ROWS               = 1024;
	localparam int DEF_QUEUE_DEPTH        = 2048;
	localparam int DEF_MAX_EVICT_PER_ITEM = 63;

	// reset value of the byte budget
	localparam logic [TOTAL_W-1:0] BUDGET_RESET = TOTAL_W'(268435456);

	// saturation limits
	localparam logic [COST_W-1:0]  COST_MAX  = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_BUDGET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b1;

	// result kinds
	localparam logic KIND_EVICT = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	// completion status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd2;

	// one entry of the per-row store
	typedef struct packed {
		logic              holds;
		logic [COST_W-1:0] cost;
	} row_entry_t;

	// order queue requests
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	// order queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// one result
	typedef struct packed {
		logic                kind;
		logic [ROW_W-1:0]    evicted_row;
		logic [TOTAL_W-1:0]  total;
		logic [STATUS_W-1:0] status;
		logic                last;
	} out_item_t;

endpackage

[hw/rtl/fbbe_ifs.sv]
// ----------------------------------------------------------------------------
// fbbe channel interfaces
// Valid/ready channels for image transactions in and result transactions out.
// ----------------------------------------------------------------------------
interface fbbe_in_if import fbbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_index;
	logic             image_null;
	logic [DIM_W-1:0] image_width;
	logic [DIM_W-1:0] image_height;
	logic [BPP_W-1:0] bits_per_pixel;

	modport source (output valid, row_index, image_null, image_width, image_height,
		bits_per_pixel, input ready);
	modport sink (input valid, row_index, image_null, image_width, image_height,
		bits_per_pixel, output ready);
endinterface

interface fbbe_out_if import fbbe_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                result_kind;
	logic [ROW_W-1:0]    evicted_row;
	logic [TOTAL_W-1:0]  total_bytes;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source (output valid, result_kind, evicted_row, total_bytes, status, last,
		input ready);
	modport sink (input valid, result_kind, evicted_row, total_bytes, status, last,
		output ready);
endinterface

[hw/rtl/fbbe_row_store.sv]
// ----------------------------------------------------------------------------
// fbbe_row_store
// Per-row cost and holds flag, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbbe_row_store import fbbe_pkg::*; #(
	parameter int ROWS = DEF_ROWS,
	localparam int RW = $clog2(ROWS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [RW-1:0] waddr,
	input  row_entry_t    wdata,
	input  logic          re,
	input  logic [RW-1:0] raddr,
	output row_entry_t    rdata
);

	row_entry_t mem [ROWS];

	// synchronous write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/fbbe_order_queue.sv]
// ----------------------------------------------------------------------------
// fbbe_order_queue
// Circular queue of row numbers in arrival order, registered pop data.
// ----------------------------------------------------------------------------
module fbbe_order_queue import fbbe_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	localparam int QW = $clog2(QUEUE_DEPTH),
	localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  q_ctrl_t          ctrl,
	input  logic [ROW_W-1:0] push_row,
	output q_stat_t          stat,
	output logic [ROW_W-1:0] pop_row
);

	logic [ROW_W-1:0] mem [QUEUE_DEPTH];
	logic [QW-1:0]    head_q;
	logic [QW-1:0]    tail_q;
	logic [FW-1:0]    fill_q;

	function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
		return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
	endfunction

	assign stat.full  = (fill_q == FW'(QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= wrap_inc(tail_q);
			end
			if (ctrl.pop) begin
				head_q <= wrap_inc(head_q);
			end
			case ({ctrl.push, ctrl.pop})
				2'b10:   fill_q <= fill_q + FW'(1);
				2'b01:   fill_q <= fill_q - FW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// storage: write at tail, read at head
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= push_row;
		end
		if (ctrl.pop) begin
			pop_row <= mem[head_q];
		end
	end

endmodule

[hw/rtl/fifo_byte_budget_eviction_unit.sv]
// ----------------------------------------------------------------------------
// fifo_byte_budget_eviction_unit
// Byte-budgeted image cache tracker with first-in first-out eviction.
//
//   channel     dir  handshake        payload
//   item_in     in   valid/ready      row_index, image_null, image_width,
//                                     image_height, bits_per_pixel
//   result_out  out  valid/ready      result_kind, evicted_row, total_bytes,
//                                     status, last
//   cfg         in   cfg_we           cfg_index, cfg_data
//
// An in-range image steps through MUL, UPD and CHECK, then QRD, EVICT and
// CHECK per queue entry popped, then DONE; an out-of-range row goes from IDLE
// to DONE. The steps follow the read-modify-write of the row store and order
// queue, both with a registered read port. After reset the row store is
// cleared, one entry per cycle, before the first transaction is accepted. A
// stalled output holds the sequencer only when a new result has to be loaded.
// ----------------------------------------------------------------------------
module fifo_byte_budget_eviction_unit import fbbe_pkg::*; #(
	parameter int ROWS               = DEF_ROWS,
	parameter int QUEUE_DEPTH        = DEF_QUEUE_DEPTH,
	parameter int MAX_EVICT_PER_ITEM = DEF_MAX_EVICT_PER_ITEM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fbbe_in_if.sink               item_in,
	fbbe_out_if.source            result_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(MAX_EVICT_PER_ITEM + 1);

	// sequencer states
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_UPD    = 3'd3;
	localparam logic [2:0] ST_CHECK  = 3'd4;
	localparam logic [2:0] ST_QRD    = 3'd5;
	localparam logic [2:0] ST_EVICT  = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0]            state_q;
	logic [RW-1:0]         clr_q;
	logic [TOTAL_W-1:0]    budget_q;
	logic [ROWCNT_W-1:0]   row_count_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [CW-1:0]         evict_cnt_q;
	logic                  out_valid_q;
	out_item_t             out_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ROW_W-1:0]      victim_q;
	logic                  victim_ok_q;

	// pipeline of the cost calculation
	logic [ROW_W-1:0]         row_s1;
	logic                     null_s1;
	logic [BPP_W-1:0]         bpp_s1;
	logic [2*DIM_W-1:0]       wh_s1;
	logic [2*DIM_W+BPP_W-1:0] prod_s2;

	// row store and queue hookup
	logic          rs_we;
	logic [RW-1:0] rs_waddr;
	row_entry_t    rs_wdata;
	logic          rs_re;
	logic [RW-1:0] rs_raddr;
	row_entry_t    rs_rdata;
	q_ctrl_t       q_ctrl;
	q_stat_t       q_stat;
	logic [ROW_W-1:0] q_pop_row;

	logic                  accept;
	logic                  in_row_ok;
	logic                  out_free;
	logic                  out_load;
	logic                  ev_go;
	logic                  evict_now;
	logic [TOTAL_W-1:0]    sub_total;
	logic [2*DIM_W+BPP_W-BYTE_SHIFT-1:0] cost_full;
	logic [COST_W-1:0]     cost;
	logic [TOTAL_W:0]      sum_total;
	logic [TOTAL_W-1:0]    new_total;

	function automatic logic row_ok(input logic [ROW_W-1:0] r,
		input logic [ROWCNT_W-1:0] cnt);
		return ({1'b0, r} < cnt) && (32'(r) < ROWS);
	endfunction

	function automatic logic [RW-1:0] to_addr(input logic [ROW_W-1:0] r);
		return RW'(r);
	endfunction

	assign accept        = item_in.valid && item_in.ready;
	assign item_in.ready = (state_q == ST_IDLE);
	assign in_row_ok     = row_ok(item_in.row_index, row_count_q);
	assign out_free      = !out_valid_q || result_out.ready;

	// total minus the cost just read from the row store, floored at zero
	assign sub_total = (total_q >= TOTAL_W'(rs_rdata.cost)) ?
		total_q - TOTAL_W'(rs_rdata.cost) : '0;

	// cost saturation and total update
	assign cost_full = prod_s2[2*DIM_W+BPP_W-1:BYTE_SHIFT];
	assign cost      = null_s1 ? '0 :
		((cost_full > (2*DIM_W+BPP_W-BYTE_SHIFT)'(COST_MAX)) ? COST_MAX
			: cost_full[COST_W-1:0]);
	assign sum_total = {1'b0, total_q} + (TOTAL_W+1)'(cost);
	assign new_total = sum_total[TOTAL_W] ? TOTAL_MAX : sum_total[TOTAL_W-1:0];

	// eviction loop conditions
	assign ev_go = (total_q > budget_q) && !q_stat.empty &&
		(evict_cnt_q < CW'(MAX_EVICT_PER_ITEM));
	assign evict_now = victim_ok_q && rs_rdata.holds;

	// a new result goes into the output register
	assign out_load = out_free &&
		(((state_q == ST_EVICT) && evict_now) || (state_q == ST_DONE));

	// row store port control
	always_comb begin
		rs_we    = 1'b0;
		rs_waddr = clr_q;
		rs_wdata = '0;
		rs_re    = 1'b0;
		rs_raddr = to_addr(item_in.row_index);
		case (state_q)
			ST_CLEAR: begin
				rs_we = 1'b1;
			end
			ST_IDLE: begin
				rs_re = accept;
			end
			ST_UPD: begin
				rs_we          = 1'b1;
				rs_waddr       = to_addr(row_s1);
				rs_wdata.holds = !null_s1;
				rs_wdata.cost  = cost;
			end
			ST_QRD: begin
				rs_re    = 1'b1;
				rs_raddr = to_addr(q_pop_row);
			end
			ST_EVICT: begin
				rs_we    = evict_now && out_free;
				rs_waddr = to_addr(victim_q);
			end
			default: begin
				rs_we = 1'b0;
			end
		endcase
	end

	// queue control
	assign q_ctrl.push = (state_q == ST_UPD) && !q_stat.full;
	assign q_ctrl.pop  = (state_q == ST_CHECK) && ev_go;

	fbbe_row_store #(
		.ROWS (ROWS)
	) u_row_store (
		.clk   (clk),
		.we    (rs_we),
		.waddr (rs_waddr),
		.wdata (rs_wdata),
		.re    (rs_re),
		.raddr (rs_raddr),
		.rdata (rs_rdata)
	);

	fbbe_order_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_order_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.push_row (row_s1),
		.stat     (q_stat),
		.pop_row  (q_pop_row)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q    <= BUDGET_RESET;
			row_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CACHE_BUDGET: budget_q    <= cfg_data[TOTAL_W-1:0];
				REG_ROW_COUNT:    row_count_q <= cfg_data[ROWCNT_W-1:0];
				default:          budget_q    <= budget_q;
			endcase
		end
	end

	// output valid: set on load, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			evict_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + RW'(1);
					if (clr_q == RW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						evict_cnt_q <= '0;
						state_q     <= in_row_ok ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					total_q <= sub_total;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					total_q <= new_total;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= ev_go ? ST_QRD : ST_DONE;
				end
				ST_QRD: begin
					state_q <= ST_EVICT;
				end
				ST_EVICT: begin
					if (!evict_now) begin
						state_q <= ST_CHECK;
					end else if (out_free) begin
						total_q     <= sub_total;
						evict_cnt_q <= evict_cnt_q + CW'(1);
						state_q     <= ST_CHECK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input capture, status, cost product and victim tracking
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1   <= item_in.row_index;
			null_s1  <= item_in.image_null;
			bpp_s1   <= item_in.bits_per_pixel;
			wh_s1    <= (2*DIM_W)'(item_in.image_width) * (2*DIM_W)'(item_in.image_height);
			status_q <= in_row_ok ? STATUS_OK : STATUS_RANGE;
		end
		if (state_q == ST_MUL) begin
			prod_s2 <= (2*DIM_W+BPP_W)'(wh_s1) * (2*DIM_W+BPP_W)'(bpp_s1);
		end
		if ((state_q == ST_UPD) && q_stat.full) begin
			status_q <= STATUS_QUEUE_FULL;
		end
		if (state_q == ST_QRD) begin
			victim_q    <= q_pop_row;
			victim_ok_q <= row_ok(q_pop_row, row_count_q);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_EVICT) && evict_now && out_free) begin
			out_q.kind        <= KIND_EVICT;
			out_q.evicted_row <= victim_q;
			out_q.total       <= sub_total;
			out_q.status      <= STATUS_OK;
			out_q.last        <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_q.kind        <= KIND_DONE;
			out_q.evicted_row <= '0;
			out_q.total       <= total_q;
			out_q.status      <= status_q;
			out_q.last        <= 1'b1;
		end
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.result_kind = out_q.kind;
	assign result_out.evicted_row = out_q.evicted_row;
	assign result_out.total_bytes = out_q.total;
	assign result_out.status      = out_q.status;
	assign result_out.last        = out_q.last;

endmodule

[hw/rtl/fbbe_checker.sv]
// ----------------------------------------------------------------------------
// fbbe_checker
// Port-level checks on the result channel of the eviction unit.
// ----------------------------------------------------------------------------
module fbbe_checker import fbbe_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic                out_kind,
	input logic [ROW_W-1:0]    out_row,
	input logic [STATUS_W-1:0] out_status,
	input logic                out_last
);

	// a pending result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// only the completion closes a transaction
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_kind == KIND_DONE)))
		else $error("last flag disagrees with result kind");

	// eviction notices carry an ok status
	a_notice_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_EVICT) |-> (out_status == STATUS_OK))
		else $error("eviction notice with nonzero status");

	// completions carry no row and a defined status code
	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_DONE) |->
			(out_row == '0) && (out_status == STATUS_OK || out_status == STATUS_RANGE ||
			out_status == STATUS_QUEUE_FULL))
		else $error("malformed completion");

endmodule

bind fifo_byte_budget_eviction_unit fbbe_checker u_fbbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.out_kind   (result_out.result_kind),
	.out_row    (result_out.evicted_row),
	.out_status (result_out.status),
	.out_last   (result_out.last)
);
